>>> rtl/mfde_pkg.sv
// Package with types and constants shared by the draw engine modules.
package mfde_pkg;
   localparam int SCREEN_WIDTH  = 84;
   localparam int SCREEN_HEIGHT = 48;
   localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W        = $clog2(STORE_SIZE);

   typedef logic [2:0] kind_type;
   localparam kind_type KIND_CLEAR  = 3'd0;
   localparam kind_type KIND_PIXEL  = 3'd1;
   localparam kind_type KIND_LINE   = 3'd2;
   localparam kind_type KIND_CIRCLE = 3'd3;
   localparam kind_type KIND_INVERT = 3'd4;
   localparam kind_type KIND_READ   = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_LINE, ST_CIRC, ST_PLOT_RD, ST_PLOT_WR,
      ST_INV_RD, ST_INV_WR, ST_READ_RD, ST_READ_WAIT, ST_DONE
   } state_type;

   // Write request into the frame store.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_req_type;
endpackage

>>> rtl/mono_framebuffer_draw_engine_core.sv
// Top level of the monochrome framebuffer draw engine.
// Commands arrive on the req_ stream, one transaction each, and each command
// returns exactly one rsp_ transaction: the byte for a read command, zero otherwise.
// The framebuffer is a 504-byte page-organized memory with a registered read port.
// One command is handled at a time. Work per command, each touched byte being
// read and then written back (read-modify-write), except for clear:
//   clear: each byte written with zero; pixel: one byte; read: one byte read;
//   line: one point per step, plotted when on screen (up to 128 steps);
//   circle: 8 octant points per step, each plotted when on screen;
//   invert: each byte in the region.
// After reset a clearing pass over all 504 bytes zeroes the memory; no command is
// taken until it ends. The result sits in an output register; while the receiver
// stalls it is held and the engine takes no new command.
module mono_framebuffer_draw_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[2:0], x_start[9:3], y_start[15:10], x_end[22:16], y_end[28:23],
   // radius[34:29], read_index[43:35], zero pad [47:44]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0]
   output logic [7:0]  rsp_tdata
);
   import mfde_pkg::*;

   state_type state_ff, state_in;
   logic [2:0]  kind_ff, kind_in;
   logic signed [10:0] x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic signed [10:0] xs_ff, xs_in, ys_ff, ys_in;  // walk position / circle a,b
   logic signed [12:0] acc_ff, acc_in;
   logic signed [10:0] major_ff, major_in, minor_ff, minor_in;
   logic [8:0]  cnt_ff, cnt_in;
   logic [2:0]  oct_ff, oct_in;
   logic        xmaj_ff, xmaj_in, sx_ff, sx_in, sy_ff, sy_in;
   logic signed [10:0] px_ff, px_in, py_ff, py_in;
   state_type   ret_ff, ret_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]  mask_ff, mask_in;
   logic [6:0]  col_ff, col_in;
   logic [2:0]  page_ff, page_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   wr_req_type  wr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]  rd_data;

   mfde_frame_ram u_ram (.clock(clock), .wr(wr), .rd_addr(rd_addr), .rd_data(rd_data));

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   wire [2:0] r_kind = req_tdata[2:0];
   wire [6:0] r_xs   = req_tdata[9:3];
   wire [5:0] r_ys   = req_tdata[15:10];
   wire [6:0] r_xe   = req_tdata[22:16];
   wire [5:0] r_ye   = req_tdata[28:23];
   wire [5:0] r_rad  = req_tdata[34:29];
   wire [8:0] r_idx  = req_tdata[43:35];

   // Line setup from request fields.
   logic signed [10:0] l_dx, l_dy;
   always_comb begin
      l_dx = (r_xe >= r_xs) ? 11'(r_xe) - 11'(r_xs) : 11'(r_xs) - 11'(r_xe);
      l_dy = (r_ye >= r_ys) ? 11'(r_ye) - 11'(r_ys) : 11'(r_ys) - 11'(r_ye);
   end

   // Circle octant point: centre (x0,y0), a=xs, b=ys.
   logic signed [10:0] cpx, cpy;
   always_comb begin
      unique case (oct_ff)
         3'd0: begin cpx = x0_ff - ys_ff; cpy = y0_ff + xs_ff; end
         3'd1: begin cpx = x0_ff - ys_ff; cpy = y0_ff - xs_ff; end
         3'd2: begin cpx = x0_ff - xs_ff; cpy = y0_ff + ys_ff; end
         3'd3: begin cpx = x0_ff - xs_ff; cpy = y0_ff - ys_ff; end
         3'd4: begin cpx = x0_ff + ys_ff; cpy = y0_ff + xs_ff; end
         3'd5: begin cpx = x0_ff + ys_ff; cpy = y0_ff - xs_ff; end
         3'd6: begin cpx = x0_ff + xs_ff; cpy = y0_ff + ys_ff; end
         default: begin cpx = x0_ff + xs_ff; cpy = y0_ff - ys_ff; end
      endcase
   end

   function automatic logic on_screen(input logic signed [10:0] x, input logic signed [10:0] y);
      return (x >= 0) && (x < SCREEN_WIDTH) && (y >= 0) && (y < SCREEN_HEIGHT);
   endfunction

   function automatic logic [ADDR_W-1:0] pix_addr(input logic signed [10:0] x,
                                                  input logic signed [10:0] y);
      logic [12:0] a;
      a = 13'(SCREEN_WIDTH) * 13'(y[5:3]) + 13'(x[6:0]);
      return a[ADDR_W-1:0];
   endfunction

   // Invert mask for the current page.
   logic [7:0] inv_mask;
   always_comb begin
      priority if (page_ff == y0_ff[5:3]) inv_mask = 8'hFF << y0_ff[2:0];
      else if (page_ff == y1_ff[5:3]) inv_mask = 8'hFF >> (4'd8 - {1'b0, y1_ff[2:0]});
      else inv_mask = 8'hFF;
   end
   wire [ADDR_W-1:0] inv_addr =
      ADDR_W'(13'(SCREEN_WIDTH) * 13'(page_ff) + 13'(col_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid && req_tready) begin
            unique case (r_kind)
               KIND_CLEAR:  state_in = ST_CLEAR;
               KIND_PIXEL:  state_in = on_screen(11'(r_xs), 11'(r_ys)) ? ST_PLOT_RD : ST_DONE;
               KIND_LINE:   state_in = ST_LINE;
               KIND_CIRCLE: state_in = ST_CIRC;
               KIND_INVERT: state_in = (r_xe > r_xs && r_ye[5:3] >= r_ys[5:3]
                                        && r_xs < SCREEN_WIDTH && r_ys[5:3] < PAGE_COUNT)
                                       ? ST_INV_RD : ST_DONE;
               KIND_READ:   state_in = ST_READ_RD;
               default:     state_in = ST_DONE;
            endcase
         end
         ST_CLEAR: if (addr_ff == ADDR_W'(STORE_SIZE - 1))
            state_in = (kind_ff == KIND_CLEAR) ? ST_DONE : ST_IDLE;
         ST_LINE: state_in = (cnt_ff == 9'd0) ? ST_DONE
                  : (on_screen(xs_ff, ys_ff) ? ST_PLOT_RD : ST_LINE);
         ST_CIRC: state_in = (xs_ff > ys_ff) ? ST_DONE
                  : (on_screen(cpx, cpy) ? ST_PLOT_RD : ST_CIRC);
         ST_PLOT_RD: state_in = ST_PLOT_WR;
         ST_PLOT_WR: state_in = ret_ff;
         ST_INV_RD: state_in = ST_INV_WR;
         ST_INV_WR: begin
            if (col_ff + 7'd1 < x1_ff[6:0] && col_ff + 7'd1 < 7'(SCREEN_WIDTH))
               state_in = ST_INV_RD;
            else if (page_ff < y1_ff[5:3] && page_ff + 3'd1 < 3'(PAGE_COUNT))
               state_in = ST_INV_RD;
            else
               state_in = ST_DONE;
         end
         ST_READ_RD: state_in = ST_READ_WAIT;
         ST_READ_WAIT: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      kind_in = kind_ff; x0_in = x0_ff; y0_in = y0_ff; x1_in = x1_ff; y1_in = y1_ff;
      xs_in = xs_ff; ys_in = ys_ff; acc_in = acc_ff; major_in = major_ff;
      minor_in = minor_ff; cnt_in = cnt_ff; oct_in = oct_ff; xmaj_in = xmaj_ff;
      sx_in = sx_ff; sy_in = sy_ff; px_in = px_ff; py_in = py_ff; ret_in = ret_ff;
      addr_in = addr_ff; mask_in = mask_ff; col_in = col_ff; page_in = page_ff;
      rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      wr = '0;
      rd_addr = addr_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid && req_tready) begin
            kind_in = r_kind;
            x0_in = 11'(r_xs); y0_in = 11'(r_ys); x1_in = 11'(r_xe); y1_in = 11'(r_ye);
            rsp_data_in = 8'd0;
            addr_in = '0;
            px_in = 11'(r_xs); py_in = 11'(r_ys);
            ret_in = ST_DONE;
            col_in = r_xs; page_in = r_ys[5:3];
            if (r_kind == KIND_READ) addr_in = r_idx[ADDR_W-1:0];
            mask_in = 8'(r_idx < 9'(STORE_SIZE));
            // Line setup.
            if (r_kind == KIND_LINE) begin
               xmaj_in = l_dx >= l_dy;
               major_in = (l_dx >= l_dy) ? l_dx : l_dy;
               minor_in = (l_dx >= l_dy) ? l_dy : l_dx;
               acc_in = 13'(((l_dx >= l_dy) ? l_dx : l_dy) >>> 1);
               cnt_in = 9'(((l_dx >= l_dy) ? l_dx : l_dy)) + 9'd1;
               sx_in = r_xe < r_xs; sy_in = r_ye < r_ys;
               xs_in = 11'(r_xs); ys_in = 11'(r_ys);
            end
            if (r_kind == KIND_CIRCLE) begin
               xs_in = '0; ys_in = 11'(r_rad);
               acc_in = 13'sd3 - 13'(2 * r_rad);
               oct_in = '0;
            end
         end
         ST_CLEAR: begin
            wr.en = 1'b1; wr.addr = addr_ff; wr.data = 8'd0;
            addr_in = addr_ff + ADDR_W'(1);
         end
         ST_LINE: if (cnt_ff != 9'd0) begin
            px_in = xs_ff; py_in = ys_ff; ret_in = ST_LINE;
            cnt_in = cnt_ff - 9'd1;
            if (acc_ff + 13'(minor_ff) >= 13'(major_ff)) begin
               acc_in = acc_ff + 13'(minor_ff) - 13'(major_ff);
               if (xmaj_ff) ys_in = sy_ff ? ys_ff - 11'sd1 : ys_ff + 11'sd1;
               else xs_in = sx_ff ? xs_ff - 11'sd1 : xs_ff + 11'sd1;
            end else begin
               acc_in = acc_ff + 13'(minor_ff);
            end
            if (xmaj_ff) xs_in = sx_ff ? xs_ff - 11'sd1 : xs_ff + 11'sd1;
            else ys_in = sy_ff ? ys_ff - 11'sd1 : ys_ff + 11'sd1;
         end
         ST_CIRC: if (xs_ff <= ys_ff) begin
            px_in = cpx; py_in = cpy; ret_in = ST_CIRC;
            oct_in = oct_ff + 3'd1;
            if (oct_ff == 3'd7) begin
               if (acc_ff < 0) begin
                  acc_in = acc_ff + 13'(4 * xs_ff) + 13'sd6;
               end else begin
                  acc_in = acc_ff + 13'(4 * (xs_ff - ys_ff)) + 13'sd10;
                  ys_in = ys_ff - 11'sd1;
               end
               xs_in = xs_ff + 11'sd1;
            end
         end
         ST_PLOT_RD: rd_addr = pix_addr(px_ff, py_ff);
         ST_PLOT_WR: begin
            wr.en = 1'b1; wr.addr = pix_addr(px_ff, py_ff);
            wr.data = rd_data | (8'd1 << py_ff[2:0]);
         end
         ST_INV_RD: rd_addr = inv_addr;
         ST_INV_WR: begin
            wr.en = 1'b1; wr.addr = inv_addr; wr.data = rd_data ^ inv_mask;
            if (col_ff + 7'd1 < x1_ff[6:0] && col_ff + 7'd1 < 7'(SCREEN_WIDTH)) begin
               col_in = col_ff + 7'd1;
            end else begin
               col_in = x0_ff[6:0]; page_in = page_ff + 3'd1;
            end
         end
         ST_READ_RD: rd_addr = addr_ff;
         ST_READ_WAIT: rsp_data_in = mask_ff[0] ? rd_data : 8'd0;
         ST_DONE: begin
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         kind_ff <= KIND_PIXEL;
         addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff <= kind_in;
         addr_ff <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x0_ff <= x0_in; y0_ff <= y0_in; x1_ff <= x1_in; y1_ff <= y1_in;
      xs_ff <= xs_in; ys_ff <= ys_in; acc_ff <= acc_in; major_ff <= major_in;
      minor_ff <= minor_in; cnt_ff <= cnt_in; oct_ff <= oct_in; xmaj_ff <= xmaj_in;
      sx_ff <= sx_in; sy_ff <= sy_in; px_ff <= px_in; py_ff <= py_in; ret_ff <= ret_in;
      mask_ff <= mask_in; col_ff <= col_in; page_ff <= page_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

>>> rtl/mfde_frame_ram.sv
// Frame store memory: one write port, one registered read port.
module mfde_frame_ram (
   input  logic                     clock,
   input  mfde_pkg::wr_req_type     wr,
   input  logic [mfde_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]               rd_data
);
   import mfde_pkg::*;
   logic [7:0] mem [STORE_SIZE];
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
